/* src/bdq_pkg.sv */
// Shared types and constants for the bounded deque with search.
`default_nettype none
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CONTAINS   = 3'd4,
        OP_REMOVE     = 3'd5
    } t_opcode;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] item_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [4:0]         occupancy;
        logic               is_empty;
        logic               found;
        logic [1:0]         error_code;
    } t_out_word;

    // Controls broadcast from the sequencer to every storage cell.
    typedef struct packed {
        logic               compare;
        logic               shift_in_prev;
        logic               shift_in_next;
        logic               remove;
        logic               append;
        logic [CNT_W-1:0]   count;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* src/bdq_cell.sv */
// One storage cell of the deque: holds an entry, compares it and shifts with its neighbors.
`default_nettype none
module bdq_cell
    import bdq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic [IDX_W-1:0]   i_idx,
    input  wire logic signed [31:0] i_prev_val,
    input  wire logic signed [31:0] i_next_val,
    input  wire logic               i_seen,
    output logic signed [31:0]      o_val,
    output logic                    o_seen
);

    logic signed [31:0] r_val;
    logic signed [31:0] n_val;
    logic               r_match;
    logic               n_match;
    logic               w_occupied;

    assign w_occupied = CNT_W'(i_idx) < i_ctl.count;

    always_comb begin
        n_match = r_match;
        if (i_ctl.compare) begin
            n_match = w_occupied && (r_val == i_ctl.value);
        end
    end

    // A removal closes the gap: the first matching cell and every one behind it take the next.
    always_comb begin
        n_val = r_val;
        if (i_ctl.shift_in_prev) begin
            n_val = i_prev_val;
        end else if (i_ctl.shift_in_next) begin
            n_val = i_next_val;
        end else if (i_ctl.remove && (i_seen || r_match)) begin
            n_val = i_next_val;
        end else if (i_ctl.append && (CNT_W'(i_idx) == i_ctl.count)) begin
            n_val = i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_match <= n_match;
    end

    assign o_val  = r_val;
    assign o_seen = i_seen || r_match;

endmodule
`default_nettype wire

/* src/bounded_deque_with_search.sv */
// Bounded deque of signed 32-bit entries built from a row of shifting cells.
// Timing: a word accepted at one edge is executed in the next cycle (r_exec), and its result
// is on o_result, marked by o_valid, once r_report has registered the execute cycle.
// Busy is high in the execute cycle, when the cells apply the match vector registered
// at accept, and no new word is accepted while it is high. The receiver cannot stall.
// Reset (synchronous, active low) empties the deque; entry contents are not cleared.
`default_nettype none
module bounded_deque_with_search
    import bdq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_in_word  i_word,
    output logic           busy,
    output logic           o_valid,
    output t_out_word      o_result
);

    logic               r_exec;
    logic               r_report;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [2:0]         r_op;
    logic signed [31:0] r_value;
    logic [1:0]         r_err;
    logic [1:0]         n_err;
    logic               r_found;
    logic               n_found;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_any_match;
    t_cell_ctl          w_ctl;
    logic [IDX_W-1:0]   w_back_idx;

    logic signed [31:0] w_val  [CAPACITY];
    logic               w_seen [CAPACITY];

    assign w_accept    = start && !busy;
    assign w_full      = r_count == CNT_W'(CAPACITY);
    assign w_empty     = r_count == '0;
    assign w_any_match = w_seen[CAPACITY-1];

    // Execute-cycle decode: status and cell controls; compare and its value are driven at accept.
    always_comb begin
        n_count = r_count;
        n_err   = ERR_OK;
        n_found = 1'b0;
        w_ctl   = '0;
        w_ctl.compare = w_accept;
        w_ctl.count   = r_count;
        w_ctl.value   = w_accept ? i_word.item_value : r_value;
        if (r_exec) begin
            unique case (r_op)
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_err = ERR_OVERFLOW;
                    end else begin
                        w_ctl.shift_in_prev = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_err = ERR_OVERFLOW;
                    end else begin
                        w_ctl.append = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (w_empty) begin
                        n_err = ERR_UNDERFLOW;
                    end else begin
                        w_ctl.shift_in_next = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_POP_BACK: begin
                    if (w_empty) begin
                        n_err = ERR_UNDERFLOW;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_CONTAINS: begin
                    n_found = w_any_match;
                end
                OP_REMOVE: begin
                    n_found = w_any_match;
                    if (w_any_match) begin
                        w_ctl.remove = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] w_prev;
        logic signed [31:0] w_next;
        logic               w_seen_in;

        if (g == 0) begin : g_first
            assign w_prev    = r_value;
            assign w_seen_in = 1'b0;
        end else begin : g_mid
            assign w_prev    = w_val[g-1];
            assign w_seen_in = w_seen[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_val[g+1];
        end

        bdq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_idx      (IDX_W'(g)),
            .i_prev_val (w_prev),
            .i_next_val (w_next),
            .i_seen     (w_seen_in),
            .o_val      (w_val[g]),
            .o_seen     (w_seen[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec   <= 1'b0;
            r_report <= 1'b0;
            r_count  <= '0;
        end else begin
            r_exec   <= w_accept;
            r_report <= r_exec;
            r_count  <= n_count;
        end
        if (w_accept) begin
            r_op    <= i_word.opcode;
            r_value <= i_word.item_value;
        end
        if (r_exec) begin
            r_err   <= n_err;
            r_found <= n_found;
        end
    end

    assign w_back_idx = IDX_W'(r_count - CNT_W'(1));

    // The report cycle reads the settled cells directly.
    always_comb begin
        o_result.front_value = w_empty ? '0 : w_val[0];
        o_result.back_value  = w_empty ? '0 : w_val[w_back_idx];
        o_result.occupancy   = 5'(r_count);
        o_result.is_empty    = w_empty;
        o_result.found       = r_found;
        o_result.error_code  = r_err;
    end

    assign busy    = r_exec;
    assign o_valid = r_report;

`ifndef NO_ASSERTIONS
    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted word was not executed in the next cycle");

    a_report_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("execute cycle was not followed by a single report");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy exceeded capacity");

    a_found_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.found) |-> (o_result.error_code == ERR_OK))
        else $error("found reported together with an error");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_op == OP_REMOVE && w_any_match) |=>
            (r_count == $past(r_count) - CNT_W'(1)))
        else $error("successful removal did not shrink the deque");
`endif

endmodule
`default_nettype wire
